/* src/ps2_host_port_macros.svh */
// Assertion macros for the PS/2 host port core RTL.
// Users must have clk and arst_n in scope.
`ifndef PS2_HOST_PORT_MACROS_SVH
`define PS2_HOST_PORT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define PS2HP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define PS2HP_NEVER(lbl, cond, msg) \
	`PS2HP_ASSERT(lbl, !(cond), msg)

`endif

/* src/ps2hp_pkg.sv */
// Package for the PS/2 host port: operation and register codes, reset values,
// transaction and configuration structs. No dependencies.
package ps2hp_pkg;

	localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
	localparam logic [3:0]  REQ_HOLD_RESET = 4'd11;
	localparam logic [3:0]  END_HOLD_RESET = 4'd4;
	localparam logic [7:0]  RESEND_RESET   = 8'hFE;
	localparam logic [3:0]  LAST_FRAME_BIT = 4'd10;
	localparam logic [3:0]  TX_IDX_MAX     = 4'd15;
	localparam int          ADDR_W         = 4;

	typedef enum logic [1:0] {
		OP_EDGE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT  = 2'd0,
		REG_REQ_HOLD = 2'd1,
		REG_END_HOLD = 2'd2,
		REG_RESEND   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] frame_timeout_ms;
		logic [3:0]  request_hold_ticks;
		logic [3:0]  end_hold_ticks;
		logic [7:0]  resend_code;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        data_level;
		logic        clock_level;
		logic [31:0] now_ms;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic       clock_drive_low;
		logic       data_drive_low;
		logic       byte_valid;
		logic [7:0] byte_out;
		logic       frame_error;
		logic       ack_missing;
	} result_t;

	function automatic logic [3:0] hold_of(input logic [3:0] v);
		hold_of = (v == 4'd0) ? 4'd1 : v;
	endfunction

endpackage

/* src/ps2hp_regs.sv */
// APB configuration registers of the PS/2 host port.
// Depends on ps2hp_pkg.
module ps2hp_regs
	import ps2hp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t wr_idx;
	reg_idx_t rd_idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_idx = reg_idx_t'(paddr[3:2]);
	assign rd_idx = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_timeout_ms   <= TIMEOUT_RESET;
			cfg_q.request_hold_ticks <= REQ_HOLD_RESET;
			cfg_q.end_hold_ticks     <= END_HOLD_RESET;
			cfg_q.resend_code        <= RESEND_RESET;
		end else if (wr_en) begin
			case (wr_idx)
				REG_TIMEOUT:  cfg_q.frame_timeout_ms   <= pwdata[15:0];
				REG_REQ_HOLD: cfg_q.request_hold_ticks <= pwdata[3:0];
				REG_END_HOLD: cfg_q.end_hold_ticks     <= pwdata[3:0];
				REG_RESEND:   cfg_q.resend_code        <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (rd_idx)
			REG_TIMEOUT:  prdata = {16'd0, cfg_q.frame_timeout_ms};
			REG_REQ_HOLD: prdata = {28'd0, cfg_q.request_hold_ticks};
			REG_END_HOLD: prdata = {28'd0, cfg_q.end_hold_ticks};
			REG_RESEND:   prdata = {24'd0, cfg_q.resend_code};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

/* src/ps2hp_core.sv */
// Line state of the PS/2 host port: receive framing, host write sequencing
// and hold timers; one transaction per step. Depends on ps2hp_pkg and macros.
`include "ps2_host_port_macros.svh"
module ps2hp_core
	import ps2hp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic        edge_mode_write_q, edge_mode_write_n;
	logic [3:0]  rx_bit_index_q, rx_bit_index_n;
	logic [7:0]  rx_shift_q, rx_shift_n;
	logic        rx_parity_q, rx_parity_n;
	logic        rx_good_q, rx_good_n;
	logic [31:0] last_edge_ms_q, last_edge_ms_n;
	logic [7:0]  tx_shift_q, tx_shift_n;
	logic [3:0]  tx_bit_index_q, tx_bit_index_n;
	logic        tx_parity_q, tx_parity_n;
	logic [3:0]  request_wait_q, request_wait_n;
	logic [3:0]  end_wait_q, end_wait_n;
	logic        clock_low_q, clock_low_n;
	logic        data_low_q, data_low_n;

	logic [31:0] gap;
	logic [3:0]  idx;
	logic [3:0]  idx_inc;
	logic [2:0]  bit_pos;
	logic        par;
	logic        txb;
	logic        valid;
	logic        ferr;
	logic        nack;
	op_t         op;

	assign op      = op_t'(item.op);
	assign gap     = item.now_ms - last_edge_ms_q;
	assign bit_pos = 3'(rx_bit_index_q - 4'd1);

	always_comb begin
		edge_mode_write_n = edge_mode_write_q;
		rx_bit_index_n    = rx_bit_index_q;
		rx_shift_n        = rx_shift_q;
		rx_parity_n       = rx_parity_q;
		rx_good_n         = rx_good_q;
		last_edge_ms_n    = last_edge_ms_q;
		tx_shift_n        = tx_shift_q;
		tx_bit_index_n    = tx_bit_index_q;
		tx_parity_n       = tx_parity_q;
		request_wait_n    = request_wait_q;
		end_wait_n        = end_wait_q;
		clock_low_n       = clock_low_q;
		data_low_n        = data_low_q;
		valid             = 1'b0;
		ferr              = 1'b0;
		nack              = 1'b0;
		idx               = rx_bit_index_q;
		idx_inc           = 4'd0;
		par               = 1'b0;
		txb               = tx_shift_q[0];
		case (op)
			OP_EDGE: begin
				if (edge_mode_write_q) begin
					if (end_wait_q == 4'd0) begin
						if (tx_bit_index_q < 4'd8) begin
							tx_shift_n  = {1'b0, tx_shift_q[7:1]};
							tx_parity_n = tx_parity_q ^ txb;
							data_low_n  = ~txb;
						end else if (tx_bit_index_q == 4'd8) begin
							data_low_n = tx_parity_q;
						end else if (tx_bit_index_q == 4'd9) begin
							data_low_n = 1'b0;
						end else begin
							nack        = item.data_level;
							end_wait_n  = hold_of(cfg.end_hold_ticks);
							clock_low_n = 1'b1;
						end
						if (tx_bit_index_q < TX_IDX_MAX)
							tx_bit_index_n = tx_bit_index_q + 4'd1;
					end
				end else if (request_wait_q == 4'd0) begin
					if (gap > {16'd0, cfg.frame_timeout_ms})
						idx = 4'd0;
					last_edge_ms_n = item.now_ms;
					if (idx == 4'd0) begin
						rx_shift_n  = 8'd0;
						rx_good_n   = ~item.data_level;
						rx_parity_n = 1'b0;
					end else if (idx <= 4'd8) begin
						if (item.data_level) begin
							rx_shift_n  = rx_shift_q | (8'd1 << bit_pos);
							rx_parity_n = ~rx_parity_q;
						end
					end else if (idx == 4'd9) begin
						par         = rx_parity_q ^ item.data_level;
						rx_parity_n = par;
						if (!par)
							rx_good_n = 1'b0;
					end else begin
						if (!item.data_level)
							rx_good_n = 1'b0;
					end
					idx_inc        = idx + 4'd1;
					rx_bit_index_n = idx_inc;
					if (idx_inc > LAST_FRAME_BIT) begin
						if (rx_good_n) begin
							valid = 1'b1;
						end else begin
							ferr           = 1'b1;
							tx_shift_n     = cfg.resend_code;
							request_wait_n = hold_of(cfg.request_hold_ticks);
						end
						rx_bit_index_n = 4'd0;
					end
				end
			end
			OP_TICK: begin
				if (request_wait_q != 4'd0) begin
					request_wait_n = request_wait_q - 4'd1;
					if (request_wait_n != 4'd0) begin
						if (item.clock_level)
							clock_low_n = 1'b1;
					end else begin
						data_low_n        = 1'b1;
						rx_bit_index_n    = 4'd0;
						tx_bit_index_n    = 4'd0;
						tx_parity_n       = 1'b0;
						edge_mode_write_n = 1'b1;
						clock_low_n       = 1'b0;
					end
				end else if (end_wait_q != 4'd0) begin
					end_wait_n = end_wait_q - 4'd1;
					if (end_wait_n != 4'd0) begin
						if (item.clock_level)
							clock_low_n = 1'b1;
					end else begin
						edge_mode_write_n = 1'b0;
						clock_low_n       = 1'b0;
					end
				end
			end
			OP_WRITE: begin
				tx_shift_n     = item.write_byte;
				request_wait_n = hold_of(cfg.request_hold_ticks);
			end
			default: ;
		endcase
	end

	always_comb begin
		res.clock_drive_low = clock_low_n;
		res.data_drive_low  = data_low_n;
		res.byte_valid      = valid;
		res.byte_out        = valid ? rx_shift_n : 8'd0;
		res.frame_error     = ferr;
		res.ack_missing     = nack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_mode_write_q <= 1'b0;
			rx_bit_index_q    <= 4'd0;
			rx_shift_q        <= 8'd0;
			rx_parity_q       <= 1'b0;
			rx_good_q         <= 1'b1;
			last_edge_ms_q    <= 32'd0;
			tx_shift_q        <= 8'd0;
			tx_bit_index_q    <= 4'd0;
			tx_parity_q       <= 1'b0;
			request_wait_q    <= 4'd0;
			end_wait_q        <= 4'd0;
			clock_low_q       <= 1'b0;
			data_low_q        <= 1'b0;
		end else if (step) begin
			edge_mode_write_q <= edge_mode_write_n;
			rx_bit_index_q    <= rx_bit_index_n;
			rx_shift_q        <= rx_shift_n;
			rx_parity_q       <= rx_parity_n;
			rx_good_q         <= rx_good_n;
			last_edge_ms_q    <= last_edge_ms_n;
			tx_shift_q        <= tx_shift_n;
			tx_bit_index_q    <= tx_bit_index_n;
			tx_parity_q       <= tx_parity_n;
			request_wait_q    <= request_wait_n;
			end_wait_q        <= end_wait_n;
			clock_low_q       <= clock_low_n;
			data_low_q        <= data_low_n;
		end
	end

	`PS2HP_ASSERT(a_rx_idx_range, rx_bit_index_q <= LAST_FRAME_BIT, "receive bit index past frame end")
	`PS2HP_NEVER(a_valid_and_err, step && res.byte_valid && res.frame_error, "byte and error together")
	`PS2HP_ASSERT(a_nack_holds_clk, step && res.ack_missing |-> res.clock_drive_low, "ack without end hold")
	`PS2HP_ASSERT(a_err_resend, step && res.frame_error |=> request_wait_q != 4'd0, "frame error without resend request")
	`PS2HP_ASSERT(a_byte_gated, res.byte_out != 8'd0 |-> res.byte_valid, "byte data without valid")

endmodule

/* src/ps2_host_port.sv */
// PS/2 host port top level: input register, line state core, result register.
// Depends on ps2hp_pkg, ps2hp_regs and ps2hp_core.
//
// Usage: each input transaction (in_valid/in_ready) carries one line event:
// op 0 is a falling clock edge with data_level and now_ms, op 1 a 20 us tick
// with clock_level, op 2 a host write request with write_byte, op 3 no-op.
// Every input transaction yields exactly one result transaction
// (out_valid/out_ready) with the host drive levels after the event, a
// received byte with byte_valid, frame_error and ack_missing.
// Flow: an accepted transaction passes the input register, then the result
// register, where out_valid rises; one transaction is taken every cycle while
// out_ready is high, the state update being one short logic pass between them.
// A stalled out_ready holds the result; one more transaction waits in the
// input register, then in_ready drops until the result is taken.
// Reset clears both stages and returns line state and registers to defaults.
// The user must write registers over APB only while no transaction is in
// flight; the block itself does not enforce this.
module ps2_host_port
	import ps2hp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic              data_level,
	input  logic              clock_level,
	input  logic [31:0]       now_ms,
	input  logic [7:0]        write_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              clock_drive_low,
	output logic              data_drive_low,
	output logic              byte_valid,
	output logic [7:0]        byte_out,
	output logic              frame_error,
	output logic              ack_missing
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;
	logic    take;

	assign adv      = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | adv;
	assign take     = in_valid & in_ready;

	ps2hp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ps2hp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op          <= op;
			item_s1.data_level  <= data_level;
			item_s1.clock_level <= clock_level;
			item_s1.now_ms      <= now_ms;
			item_s1.write_byte  <= write_byte;
		end
		if (adv)
			res_s2 <= res;
	end

	assign out_valid       = valid_s2;
	assign clock_drive_low = res_s2.clock_drive_low;
	assign data_drive_low  = res_s2.data_drive_low;
	assign byte_valid      = res_s2.byte_valid;
	assign byte_out        = res_s2.byte_out;
	assign frame_error     = res_s2.frame_error;
	assign ack_missing     = res_s2.ack_missing;

endmodule

/* tb/sv/ps2hp_line_checker.sv */
// Line checker for the PS/2 host port: mirrors APB register writes, predicts the result
// of every accepted input transaction and compares the result stream in order.
// Depends on ps2hp_pkg.
module ps2hp_line_checker
	import ps2hp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  item_t             item,
	input  logic              out_valid,
	input  logic              out_ready,
	input  result_t           seen,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t        cfg;
	logic        write_mode;
	logic [3:0]  rx_idx;
	logic [7:0]  rx_shift;
	logic        rx_par;
	logic        rx_good;
	logic [31:0] last_edge_ms;
	logic [7:0]  tx_shift;
	logic [3:0]  tx_idx;
	logic        tx_par;
	logic [3:0]  req_wait;
	logic [3:0]  end_wait;
	logic        clk_low;
	logic        dat_low;
	result_t     awaited_results[$];
	result_t     want;

	function automatic void queue_host_write(input logic [7:0] b);
		tx_shift = b;
		req_wait = (cfg.request_hold_ticks == 4'd0) ? 4'd1 : cfg.request_hold_ticks;
	endfunction

	function automatic result_t next_line_result(input item_t it);
		result_t     r;
		logic [31:0] span;
		logic        b;
		r = '0;
		case (op_t'(it.op))
			OP_EDGE: begin
				if (write_mode) begin
					if (end_wait == 4'd0) begin
						if (tx_idx < 4'd8) begin
							b = tx_shift[0];
							tx_shift = tx_shift >> 1;
							if (b)
								tx_par = !tx_par;
							dat_low = !b;
						end else if (tx_idx == 4'd8) begin
							dat_low = tx_par;
						end else if (tx_idx == 4'd9) begin
							dat_low = 1'b0;
						end else begin
							if (it.data_level)
								r.ack_missing = 1'b1;
							end_wait = (cfg.end_hold_ticks == 4'd0) ? 4'd1 : cfg.end_hold_ticks;
							clk_low = 1'b1;
						end
						if (tx_idx < TX_IDX_MAX)
							tx_idx = tx_idx + 4'd1;
					end
				end else if (req_wait == 4'd0) begin
					span = it.now_ms - last_edge_ms;
					if (span > {16'd0, cfg.frame_timeout_ms})
						rx_idx = 4'd0;
					last_edge_ms = it.now_ms;
					if (rx_idx == 4'd0) begin
						rx_shift = 8'd0;
						rx_good = !it.data_level;
						rx_par = 1'b0;
					end else if (rx_idx <= 4'd8) begin
						if (it.data_level) begin
							rx_shift = rx_shift | (8'd1 << (rx_idx - 4'd1));
							rx_par = !rx_par;
						end
					end else if (rx_idx == 4'd9) begin
						if (it.data_level)
							rx_par = !rx_par;
						if (!rx_par)
							rx_good = 1'b0;
					end else if (!it.data_level) begin
						rx_good = 1'b0;
					end
					rx_idx = rx_idx + 4'd1;
					if (rx_idx > LAST_FRAME_BIT) begin
						if (rx_good) begin
							r.byte_valid = 1'b1;
							r.byte_out = rx_shift;
						end else begin
							r.frame_error = 1'b1;
							queue_host_write(cfg.resend_code);
						end
						rx_idx = 4'd0;
					end
				end
			end
			OP_TICK: begin
				if (req_wait != 4'd0) begin
					req_wait = req_wait - 4'd1;
					if (req_wait != 4'd0) begin
						if (it.clock_level)
							clk_low = 1'b1;
					end else begin
						dat_low = 1'b1;
						rx_idx = 4'd0;
						tx_idx = 4'd0;
						tx_par = 1'b0;
						write_mode = 1'b1;
						clk_low = 1'b0;
					end
				end else if (end_wait != 4'd0) begin
					end_wait = end_wait - 4'd1;
					if (end_wait != 4'd0) begin
						if (it.clock_level)
							clk_low = 1'b1;
					end else begin
						write_mode = 1'b0;
						clk_low = 1'b0;
					end
				end
			end
			OP_WRITE: queue_host_write(it.write_byte);
			default: ;
		endcase
		r.clock_drive_low = clk_low;
		r.data_drive_low = dat_low;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t: result transaction %s expected %0d got %0d", $time, name,
				exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{TIMEOUT_RESET, REQ_HOLD_RESET, END_HOLD_RESET, RESEND_RESET};
			write_mode = 1'b0;
			rx_idx = 4'd0;
			rx_shift = 8'd0;
			rx_par = 1'b0;
			rx_good = 1'b1;
			last_edge_ms = 32'd0;
			tx_shift = 8'd0;
			tx_idx = 4'd0;
			tx_par = 1'b0;
			req_wait = 4'd0;
			end_wait = 4'd0;
			clk_low = 1'b0;
			dat_low = 1'b0;
			awaited_results.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_TIMEOUT:  cfg.frame_timeout_ms = pwdata[15:0];
					REG_REQ_HOLD: cfg.request_hold_ticks = pwdata[3:0];
					REG_END_HOLD: cfg.end_hold_ticks = pwdata[3:0];
					REG_RESEND:   cfg.resend_code = pwdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: result transaction with none expected, got %h", $time,
						seen);
				end else begin
					want = awaited_results.pop_front();
					compare_field("clock_drive_low", 8'(want.clock_drive_low),
						8'(seen.clock_drive_low));
					compare_field("data_drive_low", 8'(want.data_drive_low),
						8'(seen.data_drive_low));
					compare_field("byte_valid", 8'(want.byte_valid), 8'(seen.byte_valid));
					compare_field("byte_out", want.byte_out, seen.byte_out);
					compare_field("frame_error", 8'(want.frame_error), 8'(seen.frame_error));
					compare_field("ack_missing", 8'(want.ack_missing), 8'(seen.ack_missing));
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(next_line_result(item));
		end
		pending = awaited_results.size();
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the PS/2 host port: clock, reset, APB setup, line event stimulus and
// result backpressure; checking lives in ps2hp_line_checker.
// Depends on ps2hp_pkg, ps2_host_port and ps2hp_line_checker.
module tb_top
	import ps2hp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		FRAME_CLEAN,
		FRAME_BAD_START,
		FRAME_BAD_PARITY,
		FRAME_BAD_STOP
	} frame_flaw_t;

	typedef enum int {
		ALWAYS_READY,
		COIN_FLIP,
		MOSTLY_STALLED,
		MOSTLY_READY,
		HOLD_OFF
	} stall_style_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	item_t             stim;
	logic              out_valid;
	logic              out_ready;
	logic              clock_drive_low;
	logic              data_drive_low;
	logic              byte_valid;
	logic [7:0]        byte_out;
	logic              frame_error;
	logic              ack_missing;
	int                errors;
	int                pending;

	bit                hold_off;
	int                burst_left;
	int                items_sent;
	logic [31:0]       ms_clock;
	logic [15:0]       tmo;
	logic [3:0]        req_hold;
	logic [3:0]        end_hold;
	logic [7:0]        resend;

	ps2_host_port dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (stim.op),
		.data_level     (stim.data_level),
		.clock_level    (stim.clock_level),
		.now_ms         (stim.now_ms),
		.write_byte     (stim.write_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.clock_drive_low(clock_drive_low),
		.data_drive_low (data_drive_low),
		.byte_valid     (byte_valid),
		.byte_out       (byte_out),
		.frame_error    (frame_error),
		.ack_missing    (ack_missing)
	);

	ps2hp_line_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (stim),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.seen     ({clock_drive_low, data_drive_low, byte_valid, byte_out, frame_error,
			ack_missing}),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : result_side
		stall_style_t style;
		int           run_len;
		out_ready = 1'b0;
		forever begin
			style = stall_style_t'($urandom_range(0, 3));
			run_len = $urandom_range(5, 60);
			if (hold_off) begin
				style = HOLD_OFF;
				run_len = 300;
				hold_off = 1'b0;
			end
			repeat (run_len) begin
				@(negedge clk);
				case (style)
					ALWAYS_READY:   out_ready <= 1'b1;
					COIN_FLIP:      out_ready <= 1'($urandom);
					MOSTLY_STALLED: out_ready <= ($urandom_range(0, 7) == 0);
					MOSTLY_READY:   out_ready <= ($urandom_range(0, 3) != 0);
					default:        out_ready <= 1'b0;
				endcase
			end
		end
	end

	function automatic logic tick_level();
		return $urandom_range(0, 4) != 0;
	endfunction

	task automatic send_event(input op_t op, input logic d, input logic c,
			input logic [31:0] ms, input logic [7:0] b);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		stim <= '{op: op, data_level: d, clock_level: c, now_ms: ms, write_byte: b};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic line_edge(input logic d);
		int lim;
		lim = (tmo < 16'd3) ? int'(tmo) : 3;
		if ($urandom_range(0, 15) == 0)
			ms_clock = ms_clock + {16'd0, tmo};
		else
			ms_clock = ms_clock + $urandom_range(0, lim);
		send_event(OP_EDGE, d, 1'($urandom), ms_clock, 8'($urandom));
	endtask

	task automatic line_tick(input logic c);
		send_event(OP_TICK, 1'($urandom), c, $urandom, 8'($urandom));
	endtask

	task automatic device_frame(input logic [7:0] data, input frame_flaw_t flaw,
			input int length, input logic restart);
		logic [10:0] bits;
		int          i;
		bits = {1'b1, ~^data, data, 1'b0};
		case (flaw)
			FRAME_BAD_START:  bits[0] = 1'b1;
			FRAME_BAD_PARITY: bits[9] = ~bits[9];
			FRAME_BAD_STOP:   bits[10] = 1'b0;
			default: ;
		endcase
		if (restart)
			ms_clock = ms_clock + {16'd0, tmo} + 32'd1 + $urandom_range(0, 32'hFFFE_0000);
		for (i = 0; i < length; i++) begin
			if (i == 0 && restart)
				send_event(OP_EDGE, bits[0], 1'($urandom), ms_clock, 8'($urandom));
			else
				line_edge(bits[i]);
			if ($urandom_range(0, 9) == 0)
				line_tick(1'($urandom));
		end
	endtask

	task automatic host_write(input logic with_request);
		int hold_req;
		int hold_end;
		int k;
		bit reloaded;
		hold_req = (req_hold == 4'd0) ? 1 : int'(req_hold);
		hold_end = (end_hold == 4'd0) ? 1 : int'(end_hold);
		if (with_request)
			send_event(OP_WRITE, 1'($urandom), 1'($urandom), $urandom, 8'($urandom));
		if ($urandom_range(0, 3) == 0)
			line_edge(1'($urandom));
		repeat (hold_req) line_tick(tick_level());
		k = 0;
		reloaded = 1'b0;
		while (k < 11) begin
			if (k == 4 && !reloaded && $urandom_range(0, 7) == 0) begin
				send_event(OP_WRITE, 1'($urandom), 1'($urandom), $urandom, 8'($urandom));
				repeat (hold_req) line_tick(tick_level());
				reloaded = 1'b1;
				k = 0;
			end
			line_edge((k == 10) ? ($urandom_range(0, 5) == 0) : 1'($urandom));
			k++;
		end
		if ($urandom_range(0, 3) == 0)
			line_edge(1'($urandom));
		repeat (hold_end + $urandom_range(0, 2)) line_tick(tick_level());
	endtask

	task automatic run_phase(input int quota);
		int stop_at;
		int pick;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				device_frame(8'($urandom), FRAME_CLEAN, 11, $urandom_range(0, 3) != 0);
			end else if (pick < 60) begin
				device_frame(8'($urandom), frame_flaw_t'($urandom_range(1, 3)), 11, 1'b1);
				host_write(1'($urandom));
			end else if (pick < 75) begin
				host_write(1'b1);
			end else if (pick < 83) begin
				device_frame(8'($urandom), FRAME_CLEAN, $urandom_range(1, 10), 1'b1);
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 4))
					send_event(op_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
						$urandom, 8'($urandom));
				repeat (32) line_tick(tick_level());
				host_write(1'b1);
			end else begin
				repeat ($urandom_range(1, 5))
					send_event($urandom_range(0, 1) ? OP_TICK : OP_NOP, 1'($urandom),
						1'($urandom), $urandom, 8'($urandom));
			end
		end
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		stim = '0;
		hold_off = 1'b0;
		burst_left = 0;
		items_sent = 0;
		tmo = TIMEOUT_RESET;
		req_hold = REQ_HOLD_RESET;
		end_hold = END_HOLD_RESET;
		resend = RESEND_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_event(OP_NOP, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		send_event(OP_NOP, 1'b0, 1'b0, 32'h0000_0000, 8'h00);
		line_tick(1'b0);
		line_tick(1'b1);
		ms_clock = 32'hFFFF_FFFC;
		device_frame(8'h5A, FRAME_CLEAN, 11, 1'b0);
		send_event(OP_NOP, 1'b0, 1'b1, 32'hAAAA_5555, 8'h3C);

		for (ph = 0; ph < 6; ph++) begin
			wait_quiet();
			case (ph)
				0: begin
					tmo = TIMEOUT_RESET;
					req_hold = REQ_HOLD_RESET;
					end_hold = END_HOLD_RESET;
					resend = RESEND_RESET;
				end
				1: begin
					tmo = 16'd0;
					req_hold = 4'd1;
					end_hold = 4'd1;
					resend = 8'h00;
				end
				2: begin
					tmo = 16'hFFFF;
					req_hold = 4'd15;
					end_hold = 4'd15;
					resend = 8'hFF;
				end
				3: begin
					tmo = 16'($urandom_range(0, 300));
					req_hold = 4'd0;
					end_hold = 4'd0;
					resend = 8'($urandom);
				end
				default: begin
					tmo = 16'($urandom);
					req_hold = 4'($urandom);
					end_hold = 4'($urandom);
					resend = 8'($urandom);
				end
			endcase
			write_reg(REG_TIMEOUT, {16'd0, tmo});
			write_reg(REG_REQ_HOLD, {28'd0, req_hold});
			write_reg(REG_END_HOLD, {28'd0, end_hold});
			write_reg(REG_RESEND, {24'd0, resend});
			if (ph == 1)
				hold_off = 1'b1;
			run_phase(200);
		end
		wait_quiet();

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
